[rtl/cpu8af_pkg.sv]
// ----------------------------------------------------------------------------
// cpu8af_pkg
// Shared types and constants of the ALU flag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpu8af_pkg;

  // ALU operation codes; MODE_NOP is no operation and leaves the flags alone
  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_ADC = 3'd1,
    MODE_SUB = 3'd2,
    MODE_SBB = 3'd3,
    MODE_AND = 3'd4,
    MODE_XOR = 3'd5,
    MODE_CMP = 3'd6,
    MODE_NOP = 3'd7
  } alu_mode_e;

  // Flag bit positions in the flag byte
  localparam int unsigned FlagC  = 0;
  localparam int unsigned FlagP  = 2;
  localparam int unsigned FlagAc = 4;
  localparam int unsigned FlagZ  = 6;
  localparam int unsigned FlagS  = 7;

  localparam logic [7:0] ByteZero = 8'h00;

  // One registered operation
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [8:0] alu_result;
    logic       borrow_in;
  } alu_req_t;

endpackage

`default_nettype wire

[rtl/cpu8af_flag_calc.sv]
// ----------------------------------------------------------------------------
// cpu8af_flag_calc
// Next flag byte from one registered operation and the current flag byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8af_flag_calc (
  input  cpu8af_pkg::alu_req_t req_i,
  input  logic [7:0]           flag_i,
  output logic [7:0]           flag_o
);

  logic       carry_in;
  logic [4:0] nib_sum;
  logic       ac_add;
  logic       ac_sub;
  logic       c_sub;
  logic       c_sbb;
  logic [7:0] diff;
  logic [7:0] zsp_src;

  // Aux carry of add with carry uses the carry held before this operation
  assign carry_in = (req_i.mode == cpu8af_pkg::MODE_ADC) ? flag_i[cpu8af_pkg::FlagC] : 1'b0;
  assign nib_sum  = {1'b0, req_i.acc[3:0]} + {1'b0, req_i.operand[3:0]} + {4'b0, carry_in};
  assign ac_add   = nib_sum[4];
  assign ac_sub   = req_i.acc[3:0] < req_i.operand[3:0];
  assign c_sub    = req_i.acc < req_i.operand;
  assign c_sbb    = {1'b0, req_i.acc} < ({1'b0, req_i.operand} + {8'b0, req_i.borrow_in});
  assign diff     = req_i.acc - req_i.operand;
  assign zsp_src  = (req_i.mode == cpu8af_pkg::MODE_CMP) ? diff : req_i.alu_result[7:0];

  always_comb begin
    flag_o = flag_i;
    unique case (req_i.mode)
      cpu8af_pkg::MODE_ADD,
      cpu8af_pkg::MODE_ADC: begin
        flag_o[cpu8af_pkg::FlagC]  = req_i.alu_result[8];
        flag_o[cpu8af_pkg::FlagAc] = ac_add;
      end
      cpu8af_pkg::MODE_SUB,
      cpu8af_pkg::MODE_CMP: begin
        flag_o[cpu8af_pkg::FlagC]  = c_sub;
        flag_o[cpu8af_pkg::FlagAc] = ac_sub;
      end
      cpu8af_pkg::MODE_SBB: begin
        flag_o[cpu8af_pkg::FlagC]  = c_sbb;
        flag_o[cpu8af_pkg::FlagAc] = ac_sub;
      end
      cpu8af_pkg::MODE_AND: begin
        flag_o[cpu8af_pkg::FlagC]  = 1'b0;
        flag_o[cpu8af_pkg::FlagAc] = 1'b1;
      end
      cpu8af_pkg::MODE_XOR: begin
        flag_o[cpu8af_pkg::FlagAc] = 1'b1;
      end
      default: begin
        flag_o = flag_i;
      end
    endcase
    // Zero, sign and parity follow every defined operation
    if (req_i.mode != cpu8af_pkg::MODE_NOP) begin
      flag_o[cpu8af_pkg::FlagZ] = (zsp_src == cpu8af_pkg::ByteZero);
      flag_o[cpu8af_pkg::FlagS] = zsp_src[7];
      flag_o[cpu8af_pkg::FlagP] = ~(^zsp_src);
    end
  end

endmodule

`default_nettype wire

[rtl/cpu8_alu_flag_unit_top.sv]
// ----------------------------------------------------------------------------
// cpu8_alu_flag_unit_top
// Flag byte update unit for an 8-bit processor ALU.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one ALU operation per
//   transaction: mode, accumulator, operand, 9-bit ALU result, borrow.
//   Output channel (out_valid_o / out_stall_i) returns the updated flag byte,
//   one transaction per input transaction, in order.
//   Data path: an accepted operation is registered, then the next flag byte is
//   computed from it and the held flag byte and loaded into the flag register,
//   which drives flag_byte_o.
//   Throughput: one operation per cycle while the output is not stalled; the
//   flag register feedback is the only loop.
//   Reset: the flag byte clears to zero and both stages empty.
//   Stall: a stalled result holds in the flag register; one more operation
//   waits in the input register, then in_stall_o rises until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8_alu_flag_unit_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] acc_i,
  input  logic [7:0] operand_i,
  input  logic [8:0] alu_result_i,
  input  logic       borrow_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] flag_byte_o
);

  cpu8af_pkg::alu_req_t req_q, req_d;
  logic                 req_valid_q, req_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           flag_q, flag_d, flag_next;
  logic                 advance;
  logic                 in_accept;

  // Move the registered operation forward when the result slot is free
  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  cpu8af_flag_calc u_flag_calc (
    .req_i  (req_q),
    .flag_i (flag_q),
    .flag_o (flag_next)
  );

  always_comb begin
    req_d       = req_q;
    req_valid_d = req_valid_q;
    if (in_accept) begin
      req_d.mode       = mode_i;
      req_d.acc        = acc_i;
      req_d.operand    = operand_i;
      req_d.alu_result = alu_result_i;
      req_d.borrow_in  = borrow_in_i;
      req_valid_d      = 1'b1;
    end else if (advance) begin
      req_valid_d = 1'b0;
    end
  end

  // Flag register doubles as the output data register
  always_comb begin
    flag_d      = flag_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      flag_d      = flag_next;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      flag_q      <= cpu8af_pkg::ByteZero;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      flag_q      <= flag_d;
    end
  end

  // Payload only; no reset needed
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign out_valid_o = out_valid_q;
  assign flag_byte_o = flag_q;

endmodule

`default_nettype wire

[rtl/cpu8af_checker.sv]
// ----------------------------------------------------------------------------
// cpu8af_checker
// Port-level checks of the ALU flag unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8af_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] flag_byte_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(flag_byte_o))
    else $error("stalled flag byte changed");

  // Empty output means the pipeline has room
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Unused flag bits never leave their reset value
  a_unused_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flag_byte_o[1] == 1'b0) && (flag_byte_o[3] == 1'b0) &&
                    (flag_byte_o[5] == 1'b0))
    else $error("unused flag bit set");

endmodule

bind cpu8_alu_flag_unit_top cpu8af_checker u_cpu8af_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .flag_byte_o (flag_byte_o)
);

`default_nettype wire

[tb/cpu8_alu_flag_unit_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_flag_unit_top_tb
// Self-checking bench for the ALU flag unit. A flag tracker keeps its own copy
// of the flag byte and computes the flag byte that each accepted operation
// should produce. Every returned byte is compared in order against that
// prediction. Both channels idle at random, and one long receiver hold-off
// lets the unit fill up and push back on its input.
// ----------------------------------------------------------------------------

module cpu8_alu_flag_unit_top_tb;

  localparam int unsigned NumRandom     = 700;
  localparam int unsigned HoldOffStart  = 300;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned CycleLimit    = 200000;

  // Tracks the flag byte and holds the flag bytes still due from the unit
  class flag_tracker;
    logic [7:0] flags;
    logic [7:0] flags_due_q[$];
    int unsigned mismatches;

    function new();
      flags = cpu8af_pkg::ByteZero;
      mismatches = 0;
    endfunction

    // Note one accepted operation: work out its flag byte and queue it
    function void note_op(logic [2:0] mode, logic [7:0] acc, logic [7:0] operand,
                          logic [8:0] alu_result, logic borrow_in);
      logic [7:0] f;
      logic [7:0] zsp_src;
      logic       zsp_on;
      f = flags;
      zsp_src = alu_result[7:0];
      zsp_on = 1'b1;
      case (mode)
        cpu8af_pkg::MODE_ADD: begin
          f[cpu8af_pkg::FlagC]  = alu_result[8];
          f[cpu8af_pkg::FlagAc] = ({1'b0, acc[3:0]} + {1'b0, operand[3:0]}) > 5'h0F;
        end
        cpu8af_pkg::MODE_ADC: begin
          // aux carry takes the carry held before this operation
          f[cpu8af_pkg::FlagC]  = alu_result[8];
          f[cpu8af_pkg::FlagAc] = ({1'b0, acc[3:0]} + {1'b0, operand[3:0]} +
                                   5'(flags[cpu8af_pkg::FlagC])) > 5'h0F;
        end
        cpu8af_pkg::MODE_SUB: begin
          f[cpu8af_pkg::FlagC]  = acc < operand;
          f[cpu8af_pkg::FlagAc] = acc[3:0] < operand[3:0];
        end
        cpu8af_pkg::MODE_SBB: begin
          // borrow widens the compare to 9 bits; aux carry ignores the borrow
          f[cpu8af_pkg::FlagC]  = {1'b0, acc} < ({1'b0, operand} + 9'(borrow_in));
          f[cpu8af_pkg::FlagAc] = acc[3:0] < operand[3:0];
        end
        cpu8af_pkg::MODE_AND: begin
          f[cpu8af_pkg::FlagC]  = 1'b0;
          f[cpu8af_pkg::FlagAc] = 1'b1;
        end
        cpu8af_pkg::MODE_XOR: begin
          f[cpu8af_pkg::FlagAc] = 1'b1;
        end
        cpu8af_pkg::MODE_CMP: begin
          // compare ignores the ALU result and uses its own difference
          f[cpu8af_pkg::FlagC]  = acc < operand;
          f[cpu8af_pkg::FlagAc] = acc[3:0] < operand[3:0];
          zsp_src   = acc - operand;
        end
        default: begin
          zsp_on = 1'b0;
        end
      endcase
      if (zsp_on) begin
        f[cpu8af_pkg::FlagZ] = (zsp_src == cpu8af_pkg::ByteZero);
        f[cpu8af_pkg::FlagS] = zsp_src[7];
        f[cpu8af_pkg::FlagP] = ~^zsp_src;
      end
      flags = f;
      flags_due_q.push_back(f);
    endfunction

    // Check one returned flag byte against the oldest one due
    function void check_flags(logic [7:0] actual);
      logic [7:0] want;
      if (flags_due_q.size() == 0) begin
        $error("flag_byte: expected no result, actual 0x%02h", actual);
        mismatches++;
        return;
      end
      want = flags_due_q.pop_front();
      if (actual !== want) begin
        $error("flag_byte: expected 0x%02h, actual 0x%02h", want, actual);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return flags_due_q.size();
    endfunction
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [2:0] mode_i       = 3'd0;
  logic [7:0] acc_i        = 8'h00;
  logic [7:0] operand_i    = 8'h00;
  logic [8:0] alu_result_i = 9'h000;
  logic       borrow_in_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] flag_byte_o;

  flag_tracker tracker;
  int unsigned ops_sent    = 0;
  int unsigned cycle_count = 0;
  logic        send_burst  = 1'b0;
  logic        recv_burst  = 1'b0;
  logic        hold_off    = 1'b0;

  cpu8_alu_flag_unit_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .acc_i       (acc_i),
    .operand_i   (operand_i),
    .alu_result_i(alu_result_i),
    .borrow_in_i (borrow_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .flag_byte_o (flag_byte_o)
  );

  always #2 clk_i = ~clk_i;

  // Give up on a hung unit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one operation after a random gap, hold it until accepted, then log it.
  // Valid stays high across back-to-back transactions and only drops for a gap.
  task automatic send_op(logic [2:0] mode, logic [7:0] acc, logic [7:0] operand,
                         logic [8:0] alu_result, logic borrow_in);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i       <= mode;
    acc_i        <= acc;
    operand_i    <= operand;
    alu_result_i <= alu_result;
    borrow_in_i  <= borrow_in;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_op(mode, acc, operand, alu_result, borrow_in);
    ops_sent++;
  endtask

  // Favor the byte values where carries, borrows and sign flip
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [6];
    corners = '{8'h00, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 5)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Stimulus: directed corners first, then random operations
  initial begin
    int unsigned i;
    logic [2:0]  m;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [8:0]  r;
    logic        bw;
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Add: zero result, carry out of both nibbles, aux carry alone, zero with carry
    send_op(cpu8af_pkg::MODE_ADD, 8'h00, 8'h00, 9'h000, 1'b0);
    send_op(cpu8af_pkg::MODE_ADD, 8'hFF, 8'h01, 9'h100, 1'b0);
    // Add with carry: the held carry tips the low nibble over
    send_op(cpu8af_pkg::MODE_ADC, 8'h0E, 8'h01, 9'h010, 1'b0);
    send_op(cpu8af_pkg::MODE_ADD, 8'h0F, 8'h01, 9'h010, 1'b0);
    send_op(cpu8af_pkg::MODE_ADC, 8'h0E, 8'h01, 9'h00F, 1'b0);
    send_op(cpu8af_pkg::MODE_ADD, 8'h80, 8'h80, 9'h100, 1'b0);
    // Subtract: borrow from both nibbles, equal operands
    send_op(cpu8af_pkg::MODE_SUB, 8'h00, 8'h01, 9'h1FF, 1'b0);
    send_op(cpu8af_pkg::MODE_SUB, 8'h55, 8'h55, 9'h000, 1'b1);
    // Subtract with borrow: the borrow alone makes carry, incl. at the top of range
    send_op(cpu8af_pkg::MODE_SBB, 8'h10, 8'h10, 9'h1FF, 1'b1);
    send_op(cpu8af_pkg::MODE_SBB, 8'hFF, 8'hFF, 9'h1FF, 1'b1);
    send_op(cpu8af_pkg::MODE_SBB, 8'hFF, 8'hFE, 9'h001, 1'b0);
    send_op(cpu8af_pkg::MODE_SBB, 8'h00, 8'hFF, 9'h101, 1'b1);
    // Logic operations: carry cleared or kept, aux carry forced
    send_op(cpu8af_pkg::MODE_AND, 8'hF0, 8'h8F, 9'h080, 1'b0);
    send_op(cpu8af_pkg::MODE_AND, 8'h00, 8'hFF, 9'h000, 1'b1);
    send_op(cpu8af_pkg::MODE_XOR, 8'hFF, 8'hFF, 9'h000, 1'b0);
    send_op(cpu8af_pkg::MODE_XOR, 8'h0F, 8'hF0, 9'h0FF, 1'b1);
    // Compare: its own difference decides, whatever the ALU result says
    send_op(cpu8af_pkg::MODE_CMP, 8'h05, 8'h05, 9'h1FF, 1'b0);
    send_op(cpu8af_pkg::MODE_CMP, 8'h00, 8'hFF, 9'h000, 1'b1);
    send_op(cpu8af_pkg::MODE_CMP, 8'hFF, 8'h00, 9'h155, 1'b0);
    send_op(cpu8af_pkg::MODE_CMP, 8'h10, 8'h01, 9'h000, 1'b0);
    // No operation: flag byte returned unchanged
    send_op(cpu8af_pkg::MODE_NOP, 8'hAA, 8'h55, 9'h1AA, 1'b1);
    send_op(cpu8af_pkg::MODE_NOP, 8'h00, 8'h00, 9'h000, 1'b0);

    for (i = 0; i < NumRandom; i++) begin
      // Switch between idling and back-to-back stretches now and then
      if (i % 64 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
      end
      m  = ($urandom_range(0, 39) == 0) ? cpu8af_pkg::MODE_NOP : 3'($urandom_range(0, 6));
      a  = pick_byte();
      v  = pick_byte();
      bw = 1'($urandom_range(0, 1));
      // Mostly a result consistent with the operation, sometimes raw noise
      if ($urandom_range(0, 4) == 0) begin
        r = 9'($urandom_range(0, 511));
      end else begin
        case (m)
          cpu8af_pkg::MODE_ADD: r = {1'b0, a} + {1'b0, v};
          cpu8af_pkg::MODE_ADC: r = {1'b0, a} + {1'b0, v} + 9'($urandom_range(0, 1));
          cpu8af_pkg::MODE_SUB: r = {1'b0, a} - {1'b0, v};
          cpu8af_pkg::MODE_SBB: r = {1'b0, a} - {1'b0, v} - 9'(bw);
          cpu8af_pkg::MODE_AND: r = {1'b0, a & v};
          cpu8af_pkg::MODE_XOR: r = {1'b0, a ^ v};
          default:              r = 9'($urandom_range(0, 511));
        endcase
      end
      send_op(m, a, v, r, bw);
    end
    in_valid_i <= 1'b0;

    // Drain every outstanding flag byte, then let the unit idle before finishing
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: stall for a random gap before each transaction, and hold the
  // whole time while a hold-off is active; check each accepted flag byte.
  initial begin
    int unsigned k;
    int unsigned taken;
    taken = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) begin
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      k = recv_burst ? 0 : $urandom_range(0, 16);
      if (k > 0 || hold_off) begin
        out_stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_flags(flag_byte_o);
      taken++;
    end
  end

  // Back-pressure: once traffic is flowing, block the output for a long
  // stretch so both stages fill and the unit stalls its input.
  initial begin
    while (ops_sent < HoldOffStart) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

endmodule

[sim.f]
rtl/cpu8af_pkg.sv
rtl/cpu8af_flag_calc.sv
rtl/cpu8_alu_flag_unit_top.sv
rtl/cpu8af_checker.sv
tb/cpu8_alu_flag_unit_top_tb.sv
